### sv/dshe_pkg.sv
// ----------------------------------------------------------------------------
// dshe_pkg
// shared constants, coefficient table and control types of the hash engine
// ----------------------------------------------------------------------------
package dshe_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned SIZE_W   = 20;
    localparam int unsigned COEF_W   = 24;
    localparam int unsigned SEL_W    = 4;
    localparam int unsigned OUT_W    = 2 * SIZE_W + 2 * ACC_W;
    localparam int unsigned CNT_W    = 5;

    localparam logic [ACC_W-1:0]  PRIMARY_INIT     = 32'd0;
    localparam logic [ACC_W-1:0]  STEP_INIT        = 32'd8;
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 20'd1021;
    localparam logic [ACC_W-1:0]  STEP_MASK        = 32'h0000_8888;
    localparam logic [ACC_W-1:0]  STEP_MULT        = 32'h0000_2490;
    localparam logic [CNT_W-1:0]  DIV_LAST_CNT     = 5'd31;

    typedef struct packed {
        logic load;
        logic acc;
        logic div_start;
        logic div_step;
        logic wb;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } status_t;

    function automatic logic [COEF_W-1:0] coef(input logic [SEL_W-1:0] sel);
        logic [COEF_W-1:0] c;
        unique case (sel)
            4'h0: c = 24'h834271;
            4'h1: c = 24'h915E23;
            4'h2: c = 24'hD85447;
            4'h3: c = 24'hF71B95;
            4'h4: c = 24'hA19325;
            4'h5: c = 24'hA04C01;
            4'h6: c = 24'hE78139;
            4'h7: c = 24'h810A49;
            4'h8: c = 24'hBB1F71;
            4'h9: c = 24'hFE19E3;
            4'hA: c = 24'hC0AB43;
            4'hB: c = 24'h91A8EB;
            4'hC: c = 24'hC23AE9;
            4'hD: c = 24'hBA33E5;
            4'hE: c = 24'hED3259;
            4'hF: c = 24'hDD103D;
            default: c = 24'h834271;
        endcase
        return c;
    endfunction

endpackage

### sv/dual_string_hash_engine_top.sv
// ----------------------------------------------------------------------------
// dual_string_hash_engine_top
// key bytes: each byte is registered, then multiply-added, before the next one is taken
// reduction: after the last byte, 32-step restoring dividers reduce both hashes in
//   parallel, then the result beat is written once the output register is free
// reset: rst_n async low; accumulators go to 0 and 8, table_size to 1021
// ----------------------------------------------------------------------------
module dual_string_hash_engine_top
    import dshe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // key_byte
    input  logic              s_axis_tlast,   // last_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // home_index, probe_step, primary_raw, step_raw
    input  logic              cfg_wen,
    input  logic [SIZE_W-1:0] cfg_wdata       // table_size
);

    cmd_t    cmd;
    status_t status;

    dshe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dshe_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .key_byte  (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

### sv/dshe_ctrl.sv
// ----------------------------------------------------------------------------
// dshe_ctrl
// sequencer: byte accumulate, then 32 restoring-divide steps and write-back
// ----------------------------------------------------------------------------
module dshe_ctrl
    import dshe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last ? S_START : S_IDLE;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST_CNT)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (status.out_free)
                begin
                    cmd.wb     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### sv/dshe_datapath.sv
// ----------------------------------------------------------------------------
// dshe_datapath
// accumulators, table size register, two restoring dividers, output register
// ----------------------------------------------------------------------------
module dshe_datapath
    import dshe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [BYTE_W-1:0] key_byte,
    input  logic              last_byte,
    input  logic              cfg_wen,
    input  logic [SIZE_W-1:0] cfg_wdata,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  out_data
);

    logic [SIZE_W-1:0] table_size_reg;
    logic [ACC_W-1:0]  prim_acc_reg, step_acc_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [SEL_W-1:0]  psel_reg, ssel_reg;
    logic [ACC_W-1:0]  pquo_reg, squo_reg;
    logic [SIZE_W-1:0] prem_reg, srem_reg, prem_next, srem_next;
    logic [SIZE_W-1:0] pdiv_reg, sdiv_reg;
    logic [ACC_W-1:0]  praw_reg, sraw_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [ACC_W-1:0]  step_mix;
    logic [ACC_W-1:0]  prim_prod, step_prod;
    logic [SIZE_W:0]   pshift, sshift;
    logic [SIZE_W-1:0] home, probe;

    assign step_mix  = (step_acc_reg & STEP_MASK) * STEP_MULT;
    assign prim_prod = {{(ACC_W-COEF_W){1'b0}}, coef(psel_reg)} * {24'd0, byte_reg};
    assign step_prod = {{(ACC_W-COEF_W){1'b0}}, coef(ssel_reg)} * {24'd0, byte_reg};

    assign pshift = {prem_reg, pquo_reg[ACC_W-1]};
    assign sshift = {srem_reg, squo_reg[ACC_W-1]};

    always_comb
    begin
        prem_next = pshift[SIZE_W-1:0];
        if (pshift >= {1'b0, pdiv_reg})
        begin
            prem_next = SIZE_W'(pshift - {1'b0, pdiv_reg});
        end
        srem_next = sshift[SIZE_W-1:0];
        if (sshift >= {1'b0, sdiv_reg})
        begin
            srem_next = SIZE_W'(sshift - {1'b0, sdiv_reg});
        end
    end

    assign home  = (pdiv_reg == '0) ? '0 : prem_reg;
    assign probe = ((sdiv_reg == '0) ? '0 : srem_reg) + 1'b1;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
            prim_acc_reg   <= PRIMARY_INIT;
            step_acc_reg   <= STEP_INIT;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                table_size_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                last_reg <= last_byte;
            end
            if (cmd.acc)
            begin
                prim_acc_reg <= prim_acc_reg + prim_prod;
                step_acc_reg <= step_acc_reg + step_prod;
            end
            else if (cmd.div_start)
            begin
                prim_acc_reg <= PRIMARY_INIT;
                step_acc_reg <= STEP_INIT;
            end
            if (cmd.wb)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= key_byte;
            psel_reg <= prim_acc_reg[15:12];
            ssel_reg <= step_mix[19:16];
        end
        if (cmd.div_start)
        begin
            pquo_reg <= prim_acc_reg;
            squo_reg <= step_acc_reg;
            praw_reg <= prim_acc_reg;
            sraw_reg <= step_acc_reg;
            prem_reg <= '0;
            srem_reg <= '0;
            pdiv_reg <= table_size_reg;
            sdiv_reg <= (table_size_reg > SIZE_W'(1)) ? table_size_reg - 1'b1 : '0;
        end
        if (cmd.div_step)
        begin
            pquo_reg <= {pquo_reg[ACC_W-2:0], 1'b0};
            squo_reg <= {squo_reg[ACC_W-2:0], 1'b0};
            prem_reg <= prem_next;
            srem_reg <= srem_next;
        end
        if (cmd.wb)
        begin
            out_data_reg <= {sraw_reg, praw_reg, probe, home};
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

### sv/dshe_checker.sv
// ----------------------------------------------------------------------------
// dshe_port_checker
// port-level checks of the hash engine, bound to the top level
// ----------------------------------------------------------------------------
module dshe_port_checker
    import dshe_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // one byte in flight at a time
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("byte accepted back to back");

    // inner byte frees the input again after its accumulate step
    a_in_rate: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |-> ##2 s_axis_tready)
        else $error("inner byte did not complete in two cycles");

    // last byte keeps the input closed during reduction
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |-> ##2 !s_axis_tready)
        else $error("input reopened during reduction");

    // probe step is never zero
    a_probe_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:20] != '0)
        else $error("zero probe step");

endmodule

bind dual_string_hash_engine_top dshe_port_checker u_dshe_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
